[rtl/rnaf_pkg.sv]
// rnaf_pkg: command codes, sequencer states and read phases for the folding
// score engine. No dependencies; used by rna_fold_pair_max_table.

package rnaf_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD_BASE = 2'd0,
    CMD_LOAD_CELL = 2'd1,
    CMD_COMPUTE   = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_FINAL,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // which operand of the current cell a table read fetches
  typedef enum logic [2:0] {
    PH_SELF,
    PH_LEFT,
    PH_DOWN,
    PH_DIAG,
    PH_SPLIT_A,
    PH_SPLIT_B
  } phase_t;

  localparam logic [1:0] PAIR_SUM = 2'd3;
  localparam logic [6:0] SEQ_LEN_RESET = 7'd64;

endpackage

[rtl/rna_fold_pair_max_table.sv]
// rna_fold_pair_max_table: folding score engine, top level.
// Loads reach the result register in the cycle after they are accepted; reads
// pass the registered ram read, then the result register. Takes loads one per cycle
// while the result is not stalled; compute reads one table operand per cycle.
// Reset (rst, synchronous) clears control and sets seq_len to 64; the score
// table and base store are not cleared and hold nothing until loaded.
// Depends on rnaf_pkg and rnaf_ram.

module rna_fold_pair_max_table #(
  parameter int MAX_LEN    = 64,
  parameter int SCORE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [1:0]  cmd,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic [15:0] value,
  input  logic [1:0]  base,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] score,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int AW   = $clog2(MAX_LEN);
  localparam int XW   = $clog2(MAX_LEN + 1);
  localparam int TW   = $clog2(MAX_LEN * MAX_LEN);
  localparam int NCAP = (MAX_LEN < 127) ? MAX_LEN : 127;
  localparam int VW   = (SCORE_BITS > 16) ? SCORE_BITS : 16;
  localparam logic [SCORE_BITS-1:0] SMAX = {SCORE_BITS{1'b1}};

  function automatic logic [TW-1:0] taddr(input logic [XW-1:0] r, input logic [XW-1:0] c);
    return TW'(int'(r) * MAX_LEN + int'(c));
  endfunction

  function automatic logic [SCORE_BITS-1:0] sat_add(input logic [SCORE_BITS-1:0] a,
                                                    input logic [SCORE_BITS-1:0] b);
    logic [SCORE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SCORE_BITS] ? SMAX : s[SCORE_BITS-1:0];
  endfunction

  function automatic logic [15:0] sat_out(input logic [SCORE_BITS-1:0] v);
    logic [VW-1:0] x;
    x = VW'(v);
    return (x > VW'(16'hffff)) ? 16'hffff : 16'(x);
  endfunction

  rnaf_pkg::state_t state, state_next;
  rnaf_pkg::phase_t iss, iss_next, d_phase;

  logic [6:0]    seq_len;
  logic [6:0]    n7;
  logic [XW-1:0] n_x;
  logic [XW-1:0] i, j, k, i_next, j_next, k_next;
  logic          d_valid, issue;

  logic [1:0]            bi, bj;
  logic [SCORE_BITS-1:0] a, best, best_next, t;
  logic [SCORE_BITS-1:0] val_sat;
  logic [VW-1:0]         val_ext;
  logic                  accept, row_ok, cell_ok, pair, adj;

  logic                  s_we;
  logic [TW-1:0]         s_waddr, s_raddr;
  logic [SCORE_BITS-1:0] s_wdata, s_rdata;
  logic                  b_we;
  logic [AW-1:0]         b_waddr, b_raddr;
  logic [1:0]            b_rdata;

  logic        res_load, status_next;
  logic [15:0] score_next;

  rnaf_ram #(.WIDTH(SCORE_BITS), .DEPTH(MAX_LEN * MAX_LEN)) u_table (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  rnaf_ram #(.WIDTH(2), .DEPTH(MAX_LEN)) u_bases (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (base),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign cfg_ready = 1'b1;
  assign n7        = (seq_len > 7'(NCAP)) ? 7'(NCAP) : seq_len;
  assign n_x       = XW'(n7);
  assign row_ok    = {1'b0, row} < n7;
  assign cell_ok   = row_ok && ({1'b0, col} < n7);
  assign cmd_stall = (state != rnaf_pkg::ST_IDLE) || (res_valid && res_stall);
  assign accept    = cmd_valid && !cmd_stall;

  assign val_ext = VW'(value);
  assign val_sat = (val_ext > VW'(SMAX)) ? SMAX : SCORE_BITS'(val_ext);

  assign adj  = (j == i + XW'(1));
  assign pair = ({1'b0, bi} + {1'b0, bj}) == {1'b0, rnaf_pkg::PAIR_SUM};

  // fold the returning operand into the running maximum of the cell
  always_comb begin
    t = '0;
    case (d_phase)
      rnaf_pkg::PH_LEFT,
      rnaf_pkg::PH_DOWN:    t = s_rdata;
      rnaf_pkg::PH_DIAG:    t = (pair && !adj) ? sat_add(s_rdata, SCORE_BITS'(1)) : s_rdata;
      rnaf_pkg::PH_SPLIT_B: t = sat_add(a, s_rdata);
      default:              t = '0;
    endcase
    if (!d_valid) begin
      best_next = best;
    end else if (d_phase == rnaf_pkg::PH_SELF) begin
      best_next = s_rdata;
    end else begin
      best_next = (t > best) ? t : best;
    end
  end

  always_comb begin
    state_next  = state;
    i_next      = i;
    j_next      = j;
    k_next      = k;
    iss_next    = iss;
    issue       = 1'b0;
    s_we        = 1'b0;
    s_waddr     = taddr(i, j);
    s_wdata     = best_next;
    s_raddr     = taddr(i, j);
    b_we        = 1'b0;
    b_waddr     = AW'(row);
    b_raddr     = AW'(i);
    res_load    = 1'b0;
    score_next  = '0;
    status_next = 1'b0;
    case (state)
      rnaf_pkg::ST_IDLE: begin
        if (accept) begin
          case (rnaf_pkg::cmd_t'(cmd))
            rnaf_pkg::CMD_LOAD_BASE: begin
              res_load    = 1'b1;
              b_we        = row_ok;
              status_next = !row_ok;
            end
            rnaf_pkg::CMD_LOAD_CELL: begin
              res_load    = 1'b1;
              s_we        = cell_ok;
              s_waddr     = taddr(XW'(row), XW'(col));
              s_wdata     = val_sat;
              status_next = !cell_ok;
            end
            rnaf_pkg::CMD_COMPUTE: begin
              if (n7 == 7'd0) begin
                res_load = 1'b1;
              end else if (n7 == 7'd1) begin
                state_next = rnaf_pkg::ST_FINAL;
              end else begin
                i_next     = n_x - XW'(2);
                j_next     = n_x - XW'(1);
                iss_next   = rnaf_pkg::PH_SELF;
                state_next = rnaf_pkg::ST_ISSUE;
              end
            end
            rnaf_pkg::CMD_READ: begin
              s_raddr = taddr(XW'(row), XW'(col));
              if (cell_ok) begin
                state_next = rnaf_pkg::ST_RD;
              end else begin
                res_load    = 1'b1;
                status_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      rnaf_pkg::ST_RD: begin
        res_load   = 1'b1;
        score_next = sat_out(s_rdata);
        state_next = rnaf_pkg::ST_IDLE;
      end
      rnaf_pkg::ST_FINAL: begin
        s_raddr    = taddr('0, n_x - XW'(1));
        state_next = rnaf_pkg::ST_RD;
      end
      rnaf_pkg::ST_ISSUE: begin
        issue = 1'b1;
        case (iss)
          rnaf_pkg::PH_SELF: begin
            s_raddr  = taddr(i, j);
            b_raddr  = AW'(i);
            iss_next = rnaf_pkg::PH_LEFT;
          end
          rnaf_pkg::PH_LEFT: begin
            s_raddr  = taddr(i, j - XW'(1));
            b_raddr  = AW'(j);
            iss_next = rnaf_pkg::PH_DOWN;
          end
          rnaf_pkg::PH_DOWN: begin
            s_raddr  = taddr(i + XW'(1), j);
            iss_next = rnaf_pkg::PH_DIAG;
          end
          rnaf_pkg::PH_DIAG: begin
            s_raddr = taddr(i + XW'(1), j - XW'(1));
            if (adj) begin
              state_next = rnaf_pkg::ST_DRAIN;
            end else begin
              k_next   = i + XW'(1);
              iss_next = rnaf_pkg::PH_SPLIT_A;
            end
          end
          rnaf_pkg::PH_SPLIT_A: begin
            s_raddr  = taddr(i, k);
            iss_next = rnaf_pkg::PH_SPLIT_B;
          end
          rnaf_pkg::PH_SPLIT_B: begin
            s_raddr = taddr(k + XW'(1), j);
            if (k + XW'(1) == j) begin
              state_next = rnaf_pkg::ST_DRAIN;
            end else begin
              k_next   = k + XW'(1);
              iss_next = rnaf_pkg::PH_SPLIT_A;
            end
          end
          default: iss_next = rnaf_pkg::PH_SELF;
        endcase
      end
      rnaf_pkg::ST_DRAIN: begin
        // last operand lands now; write the cell and move to the next one
        s_we     = 1'b1;
        iss_next = rnaf_pkg::PH_SELF;
        if (j + XW'(1) < n_x) begin
          j_next     = j + XW'(1);
          state_next = rnaf_pkg::ST_ISSUE;
        end else if (i == '0) begin
          state_next = rnaf_pkg::ST_FINAL;
        end else begin
          i_next     = i - XW'(1);
          j_next     = i;
          state_next = rnaf_pkg::ST_ISSUE;
        end
      end
      default: state_next = rnaf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rnaf_pkg::ST_IDLE;
      res_valid <= 1'b0;
      d_valid   <= 1'b0;
      seq_len   <= rnaf_pkg::SEQ_LEN_RESET;
    end else begin
      state   <= state_next;
      d_valid <= issue;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        seq_len <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i       <= i_next;
    j       <= j_next;
    k       <= k_next;
    iss     <= iss_next;
    d_phase <= iss;
    best    <= best_next;
    if (d_valid && d_phase == rnaf_pkg::PH_SELF) begin
      bi <= b_rdata;
    end
    if (d_valid && d_phase == rnaf_pkg::PH_LEFT) begin
      bj <= b_rdata;
    end
    if (d_valid && d_phase == rnaf_pkg::PH_SPLIT_A) begin
      a <= s_rdata;
    end
    if (res_load) begin
      score  <= score_next;
      status <= status_next;
    end
  end

endmodule

[rtl/rnaf_ram.sv]
// rnaf_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.

module rnaf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// tb: self-checking bench for rna_fold_pair_max_table, loads, reads and folds
// checked beat by beat against an in-bench score table. Depends on rnaf_pkg.

module tb;

  localparam int TAB_DIM     = 64;
  localparam int STALL_LIMIT = 400_000;

  typedef struct {
    rnaf_pkg::cmd_t op;
    logic [5:0]     r;
    logic [5:0]     c;
    logic [15:0]    v;
    logic [1:0]     b;
    bit             hold;
  } fold_cmd_t;

  typedef struct packed {
    logic [15:0] score;
    logic        status;
  } fold_ans_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cmd_valid = 1'b0;
  logic           cmd_stall;
  rnaf_pkg::cmd_t cmd = rnaf_pkg::CMD_LOAD_BASE;
  logic [5:0]     row = '0;
  logic [5:0]     col = '0;
  logic [15:0]    value = '0;
  logic [1:0]     base = '0;
  logic           res_valid;
  logic           res_stall = 1'b0;
  logic [15:0]    score;
  logic           status;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [6:0]     cfg_data = '0;

  rna_fold_pair_max_table u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .row       (row),
    .col       (col),
    .value     (value),
    .base      (base),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .score     (score),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // bench copy of the engine state
  logic [15:0] fold_tab [0:TAB_DIM*TAB_DIM-1];
  logic [1:0]  fold_base [0:TAB_DIM-1];
  logic [6:0]  fold_len = rnaf_pkg::SEQ_LEN_RESET;

  fold_cmd_t cmd_pend_q[$];
  fold_ans_t answer_due_q[$];

  // generator view of what has been loaded at the current length
  bit cell_set [0:TAB_DIM*TAB_DIM-1];
  bit base_set [0:TAB_DIM-1];
  int gen_n = TAB_DIM;
  int pushed = 0;

  int fails = 0;
  int idle_run = 0;
  logic cmd_took = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int stall_run = 0;

  function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hffff : s[15:0];
  endfunction

  function automatic void fold_fill(input int n);
    int i, j, k;
    logic [15:0] best, t;
    logic [2:0] pair;
    for (i = n - 1; i >= 0; i--) begin
      for (j = i + 1; j < n; j++) begin
        best = fold_tab[i*TAB_DIM + j];
        if (fold_tab[i*TAB_DIM + j - 1] > best) best = fold_tab[i*TAB_DIM + j - 1];
        if (fold_tab[(i+1)*TAB_DIM + j] > best) best = fold_tab[(i+1)*TAB_DIM + j];
        t = fold_tab[(i+1)*TAB_DIM + j - 1];
        pair = {1'b0, fold_base[i]} + {1'b0, fold_base[j]};
        // adjacent bases take the lower-left cell without the pair bonus
        if (i + 1 < j && pair == {1'b0, rnaf_pkg::PAIR_SUM}) t = sat_sum(t, 16'd1);
        if (t > best) best = t;
        for (k = i + 1; k < j; k++) begin
          t = sat_sum(fold_tab[i*TAB_DIM + k], fold_tab[(k+1)*TAB_DIM + j]);
          if (t > best) best = t;
        end
        fold_tab[i*TAB_DIM + j] = best;
      end
    end
  endfunction

  function automatic fold_ans_t fold_step(input rnaf_pkg::cmd_t op, input logic [5:0] r,
                                          input logic [5:0] c, input logic [15:0] v,
                                          input logic [1:0] b);
    int n;
    fold_ans_t a;
    n = (fold_len > TAB_DIM) ? TAB_DIM : int'(fold_len);
    a = '0;
    case (op)
      rnaf_pkg::CMD_LOAD_BASE: begin
        if (r < n) fold_base[r] = b;
        else a.status = 1'b1;
      end
      rnaf_pkg::CMD_LOAD_CELL: begin
        if (r < n && c < n) fold_tab[{r, c}] = v;
        else a.status = 1'b1;
      end
      rnaf_pkg::CMD_COMPUTE: begin
        if (n > 0) begin
          fold_fill(n);
          a.score = fold_tab[n - 1];
        end
      end
      default: begin
        if (r < n && c < n) a.score = fold_tab[{r, c}];
        else a.status = 1'b1;
      end
    endcase
    return a;
  endfunction

  task automatic report(input string msg);
    if (fails < 100) $display("%0t mismatch: %s", $time, msg);
    fails++;
  endtask

  // result checking, prediction and watchdog
  always @(posedge clk) begin
    fold_ans_t due;
    bit beat;
    if (rst) begin
      fold_len = rnaf_pkg::SEQ_LEN_RESET;
      cmd_took <= 1'b0;
      idle_run <= 0;
    end else begin
      beat = 0;
      if (res_valid && !res_stall) begin
        beat = 1;
        if (answer_due_q.size() == 0) begin
          report($sformatf("result beat with nothing outstanding, score %0d status %0d",
                           score, status));
        end else begin
          due = answer_due_q.pop_front();
          if (score !== due.score)
            report($sformatf("score got %0d want %0d", score, due.score));
          if (status !== due.status)
            report($sformatf("status got %0d want %0d", status, due.status));
        end
      end
      if (cfg_valid && cfg_ready) begin
        beat = 1;
        fold_len = cfg_data;
      end
      if (cmd_valid && !cmd_stall) begin
        beat = 1;
        answer_due_q.push_back(fold_step(cmd, row, col, value, base));
      end
      cmd_took <= cmd_valid && !cmd_stall;
      if (beat) begin
        idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // command sender: bursts with random gaps
  always @(negedge clk) begin
    fold_cmd_t nxt;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_took) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (cmd_pend_q.size() > 0 &&
                   !(cmd_pend_q[0].hold && answer_due_q.size() != 0)) begin
        nxt = cmd_pend_q.pop_front();
        cmd   <= nxt.op;
        row   <= nxt.r;
        col   <= nxt.c;
        value <= nxt.v;
        base  <= nxt.b;
        cmd_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = int'($urandom_range(0, 30));
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // result receiver stalls in runs of random length
  always @(negedge clk) begin
    bit s;
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      s = ($urandom_range(0, 2) == 0);
      res_stall <= s;
      stall_run = s ? int'($urandom_range(0, 6)) : int'($urandom_range(0, 30));
    end
  end

  function automatic logic [15:0] pick_score(input bit hot);
    int sel;
    sel = int'($urandom_range(0, 19));
    if (hot && sel == 0) return 16'hffff;
    if (hot && sel == 1) return 16'hffff - 16'($urandom_range(1, 6));
    if (hot && sel == 2) return 16'h0;
    if (sel == 3) return 16'($urandom);
    return 16'($urandom_range(0, 5));
  endfunction

  // mostly in range, sometimes past the active length
  function automatic int pick_idx(input int n);
    if (n == 0 || (n < TAB_DIM && $urandom_range(0, 4) == 0))
      return int'($urandom_range(n, 63));
    return int'($urandom_range(0, n - 1));
  endfunction

  task automatic queue_cmd(input rnaf_pkg::cmd_t op, input int r, input int c,
                           input logic [15:0] v, input logic [1:0] b, input bit hold);
    fold_cmd_t it;
    it.op = op;
    it.r = 6'(r);
    it.c = 6'(c);
    it.v = v;
    it.b = b;
    it.hold = hold;
    if (op == rnaf_pkg::CMD_LOAD_BASE && r < gen_n) base_set[r] = 1'b1;
    if (op == rnaf_pkg::CMD_LOAD_CELL && r < gen_n && c < gen_n)
      cell_set[r*TAB_DIM + c] = 1'b1;
    cmd_pend_q.push_back(it);
    pushed++;
  endtask

  task automatic ld_base(input int r, input logic [1:0] b);
    queue_cmd(rnaf_pkg::CMD_LOAD_BASE, r, int'($urandom_range(0, 63)), 16'($urandom), b,
              1'b0);
  endtask

  task automatic ld_cell(input int r, input int c, input logic [15:0] v);
    queue_cmd(rnaf_pkg::CMD_LOAD_CELL, r, c, v, 2'($urandom_range(0, 3)), 1'b0);
  endtask

  task automatic rd_cell(input int r, input int c, input bit hold);
    queue_cmd(rnaf_pkg::CMD_READ, r, c, 16'($urandom), 2'($urandom_range(0, 3)), hold);
  endtask

  task automatic cmd_fold(input bit hold);
    queue_cmd(rnaf_pkg::CMD_COMPUTE, int'($urandom_range(0, 63)), int'($urandom_range(0, 63)),
              16'($urandom), 2'($urandom_range(0, 3)), hold);
  endtask

  // load every base and every cell a fold of length n touches
  task automatic prime(input int n, input bit hot);
    int r, c;
    bit redo;
    for (r = 0; r < n; r++) begin
      redo = (n <= 16) && ($urandom_range(0, 2) == 0);
      if (!base_set[r] || redo) ld_base(r, 2'($urandom_range(0, 3)));
    end
    for (r = 0; r < n; r++) begin
      for (c = (r > 0) ? r - 1 : 0; c < n; c++) begin
        redo = (n <= 16) && ($urandom_range(0, 2) == 0);
        if (!cell_set[r*TAB_DIM + c] || redo) ld_cell(r, c, pick_score(hot));
      end
    end
  endtask

  task automatic random_cmd(input int n);
    int sel, r, c;
    sel = int'($urandom_range(0, 99));
    if (sel < 22) begin
      ld_base(pick_idx(n), 2'($urandom_range(0, 3)));
    end else if (sel < 44) begin
      ld_cell(pick_idx(n), pick_idx(n), pick_score($urandom_range(0, 2) == 0));
    end else if (sel < 88 || n > 12) begin
      r = pick_idx(n);
      c = pick_idx(n);
      if (r < n && c < n && !cell_set[r*TAB_DIM + c]) ld_cell(r, c, pick_score(1'b0));
      rd_cell(r, c, $urandom_range(0, 49) == 0);
    end else begin
      prime(n, $urandom_range(0, 3) == 0);
      cmd_fold($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic settle();
    do @(posedge clk);
    while (cmd_pend_q.size() != 0 || cmd_valid || answer_due_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_len(input logic [6:0] len);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_n = (len > TAB_DIM) ? TAB_DIM : int'(len);
  endtask

  initial begin
    int phase_len [16] = '{5, 0, 1, 2, 12, 127, 3, 8, 65, 6, 4, 10, 7, 2, 1, 9};
    int goal;
    foreach (fold_tab[i]) fold_tab[i] = '0;
    foreach (fold_base[i]) fold_base[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corners of the table at the reset length
    ld_base(0, 2'd0);
    ld_base(63, 2'd3);
    ld_base(1, 2'd1);
    ld_base(2, 2'd2);
    ld_cell(0, 0, 16'h0000);
    ld_cell(63, 63, 16'hffff);
    ld_cell(0, 63, 16'h5555);
    ld_cell(63, 0, 16'haaaa);
    rd_cell(63, 63, 1'b0);
    rd_cell(0, 63, 1'b0);
    rd_cell(63, 0, 1'b1);
    rd_cell(0, 0, 1'b0);

    // zero length: everything refused, fold answers zero
    write_len(7'd0);
    ld_base(0, 2'd1);
    ld_cell(0, 0, 16'd9);
    rd_cell(0, 0, 1'b0);
    cmd_fold(1'b0);

    // adjacent pair takes the lower-left cell without bonus
    write_len(7'd2);
    ld_base(0, 2'd0);
    ld_base(1, 2'd3);
    ld_cell(0, 0, 16'd2);
    ld_cell(0, 1, 16'd0);
    ld_cell(1, 0, 16'd7);
    ld_cell(1, 1, 16'd1);
    cmd_fold(1'b0);
    rd_cell(0, 1, 1'b0);

    // pair bonus and split sums saturating
    write_len(7'd3);
    ld_base(2, 2'd3);
    ld_cell(1, 1, 16'hffff);
    ld_cell(0, 2, 16'd0);
    ld_cell(1, 2, 16'd0);
    ld_cell(2, 1, 16'd0);
    ld_cell(2, 2, 16'hffff);
    cmd_fold(1'b1);
    rd_cell(1, 2, 1'b0);

    // random commands at each length; lengths past the table size run at the full table
    foreach (phase_len[p]) begin
      write_len(7'(phase_len[p]));
      goal = pushed + 100;
      while (pushed < goal) random_cmd(gen_n);
    end

    settle();
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rnaf_pkg.sv
rtl/rnaf_ram.sv
rtl/rna_fold_pair_max_table.sv
tb/tb.sv
